[src/typed_atomic_memory_unit_top_defines.svh]
// ----------------------------------------------------------------------------
// typed atomic memory unit assertion macros
// shared property shorthands for the checker, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef TYPED_ATOMIC_MEMORY_UNIT_TOP_DEFINES_SVH
`define TYPED_ATOMIC_MEMORY_UNIT_TOP_DEFINES_SVH

// same-cycle implication
`define TAMU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tamu_pkg.sv]
// ----------------------------------------------------------------------------
// tamu_pkg
// shared codes, command and status bundles and element type helpers
// ----------------------------------------------------------------------------
package tamu_pkg;

  // default store size in bytes
  localparam int DEF_STORE_BYTES = 4096;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_TYPE   = 2'd2;

  // operation codes
  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_STORE = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_AND   = 4'd3;
  localparam logic [3:0] OP_XCHG  = 4'd4;
  localparam logic [3:0] OP_OR    = 4'd5;
  localparam logic [3:0] OP_SUB   = 4'd6;
  localparam logic [3:0] OP_XOR   = 4'd7;
  localparam logic [3:0] OP_CAS   = 4'd8;

  // element types
  localparam logic [3:0] TY_I8   = 4'd0;
  localparam logic [3:0] TY_I16  = 4'd1;
  localparam logic [3:0] TY_I32  = 4'd2;
  localparam logic [3:0] TY_U8   = 4'd3;
  localparam logic [3:0] TY_U16  = 4'd4;
  localparam logic [3:0] TY_U32  = 4'd5;
  localparam logic [3:0] TY_U8C  = 4'd6;
  localparam logic [3:0] TY_I64  = 4'd7;
  localparam logic [3:0] TY_U64  = 4'd8;

  // response status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_TYPE  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic clear;
    logic capture;
    logic check;
    logic read;
    logic commit;
  } tamu_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } tamu_sts_t;

  // usable element type (clamped and unknown types are not)
  function automatic logic type_ok(input logic [3:0] et);
    logic ok;
    case (et)
      TY_I8, TY_I16, TY_I32, TY_U8, TY_U16, TY_U32, TY_I64, TY_U64: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // log2 of element size in bytes
  function automatic logic [1:0] type_lg(input logic [3:0] et);
    logic [1:0] lg;
    case (et)
      TY_I16, TY_U16: lg = 2'd1;
      TY_I32, TY_U32: lg = 2'd2;
      TY_I64, TY_U64: lg = 2'd3;
      default:        lg = 2'd0;
    endcase
    return lg;
  endfunction

  // signed element type
  function automatic logic type_sgn(input logic [3:0] et);
    logic s;
    case (et)
      TY_I8, TY_I16, TY_I32, TY_I64: s = 1'b1;
      default: s = 1'b0;
    endcase
    return s;
  endfunction

  // mask of the element width
  function automatic logic [63:0] width_mask(input logic [1:0] lg);
    logic [63:0] m;
    case (lg)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // sign or zero extension of a masked element
  function automatic logic [63:0] extend(input logic [63:0] v, input logic [1:0] lg,
                                         input logic sgn);
    logic [63:0] r;
    case (lg)
      2'd0:    r = {{56{sgn & v[7]}}, v[7:0]};
      2'd1:    r = {{48{sgn & v[15]}}, v[15:0]};
      2'd2:    r = {{32{sgn & v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

[src/tamu_req_if.sv]
// ----------------------------------------------------------------------------
// tamu_req_if
// request channel: valid/ready handshake with the request fields
// ----------------------------------------------------------------------------
interface tamu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [31:0] elem_index;
  logic        index_invalid;
  logic signed [63:0] operand;
  logic signed [63:0] expected_value;

  modport source (output valid, output op, output elem_index, output index_invalid,
                  output operand, output expected_value, input ready);
  modport sink (input valid, input op, input elem_index, input index_invalid,
                input operand, input expected_value, output ready);
endinterface

[src/tamu_rsp_if.sv]
// ----------------------------------------------------------------------------
// tamu_rsp_if
// response channel: valid/ready handshake with the result fields
// ----------------------------------------------------------------------------
interface tamu_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] old_value;
  logic [1:0]  status;

  modport source (output valid, output old_value, output status, input ready);
  modport sink (input valid, input old_value, input status, output ready);
endinterface

[src/tamu_ctrl.sv]
// ----------------------------------------------------------------------------
// tamu_ctrl
// sequencer: clearing pass after reset, then check, read and commit per request
// ----------------------------------------------------------------------------
module tamu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output tamu_pkg::tamu_cmd_t cmd,
  input  tamu_pkg::tamu_sts_t sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

[src/tamu_datapath.sv]
// ----------------------------------------------------------------------------
// tamu_datapath
// config registers, request checks, eight byte-wide banks, alu and result register
// ----------------------------------------------------------------------------
module tamu_datapath #(
  parameter int STORE_BYTES = tamu_pkg::DEF_STORE_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  // config
  input  logic                                cfg_wr_en,
  input  logic [tamu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tamu_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request fields
  input  logic [3:0]                          op,
  input  logic [31:0]                         elem_index,
  input  logic                                index_invalid,
  input  logic [63:0]                         operand,
  input  logic [63:0]                         expected_value,
  // result
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [63:0]                         old_value,
  output logic [1:0]                          status,
  // control
  input  tamu_pkg::tamu_cmd_t                 cmd,
  output tamu_pkg::tamu_sts_t                 sts
);

  localparam int ROWS = (STORE_BYTES + 7) / 8;
  localparam int RW   = $clog2(ROWS);
  localparam int SBW  = $clog2(STORE_BYTES + 1);
  localparam int PW   = ((SBW > 17) ? SBW : 17) + 1;
  localparam logic [PW-1:0] STORE_LIM = PW'(STORE_BYTES);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

  // config registers
  logic [11:0] view_offset;
  logic [12:0] view_length;
  logic [3:0]  elem_type;

  // captured request
  logic [3:0]  r_op;
  logic [31:0] r_idx;
  logic        r_bad;
  logic [63:0] r_operand;
  logic [63:0] r_expv;

  // check results
  logic [1:0]    chk_status;
  logic [PW-1:0] pos;
  logic [1:0]    lg;
  logic          sgn;

  // read data, one byte per bank
  logic [63:0] rd_word;

  // clearing pass row
  logic [RW-1:0] clear_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_offset <= '0;
      view_length <= '0;
      elem_type   <= tamu_pkg::TY_I32;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tamu_pkg::CFG_VIEW_OFFSET: view_offset <= cfg_data[11:0];
        tamu_pkg::CFG_VIEW_LENGTH: view_length <= cfg_data[12:0];
        tamu_pkg::CFG_ELEM_TYPE:   elem_type   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_op      <= op;
      r_idx     <= elem_index;
      r_bad     <= index_invalid;
      r_operand <= operand;
      r_expv    <= expected_value;
    end
  end

  // type and range checks, byte position of the element
  logic          type_err;
  logic          range_err;
  logic [1:0]    lg_c;
  logic [PW-1:0] pos_c;
  logic [PW-1:0] end_c;

  always_comb begin
    lg_c      = tamu_pkg::type_lg(elem_type);
    type_err  = (r_op > tamu_pkg::OP_CAS) || !tamu_pkg::type_ok(elem_type);
    pos_c     = PW'(view_offset) + (PW'(r_idx[12:0]) << lg_c);
    end_c     = pos_c + (PW'(1) << lg_c);
    range_err = r_bad || (r_idx >= 32'(view_length)) || (end_c > STORE_LIM);
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      chk_status <= type_err  ? tamu_pkg::ST_TYPE  :
                    range_err ? tamu_pkg::ST_RANGE : tamu_pkg::ST_OK;
      pos        <= pos_c;
      lg         <= lg_c;
      sgn        <= tamu_pkg::type_sgn(elem_type);
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_row <= '0;
    end else if (cmd.clear) begin
      clear_row <= clear_row + RW'(1);
    end
  end

  // element bytes: byte k of the element lives in bank (base + k) mod 8
  logic [2:0]    base;
  logic [RW-1:0] row0;
  logic [63:0]   mask;
  logic [63:0]   old_raw;
  logic [63:0]   old_m;
  logic [63:0]   nv;
  logic          do_write;
  logic [RW-1:0] bank_addr [8];
  logic [7:0]    wbyte     [8];
  logic          lane_en   [8];

  assign base = pos[2:0];
  assign row0 = pos[RW+2:3];
  assign mask = tamu_pkg::width_mask(lg);

  always_comb begin
    logic [2:0] sel;
    logic [2:0] k;
    for (int i = 0; i < 8; i++) begin
      sel = 3'(i) + base;
      old_raw[8*i +: 8] = rd_word[8*sel +: 8];
    end
    old_m = old_raw & mask;

    // new element value
    do_write = 1'b1;
    case (r_op)
      tamu_pkg::OP_LOAD: begin
        nv       = old_m;
        do_write = 1'b0;
      end
      tamu_pkg::OP_ADD: nv = old_m + r_operand;
      tamu_pkg::OP_AND: nv = old_m & r_operand;
      tamu_pkg::OP_OR:  nv = old_m | r_operand;
      tamu_pkg::OP_SUB: nv = old_m - r_operand;
      tamu_pkg::OP_XOR: nv = old_m ^ r_operand;
      tamu_pkg::OP_CAS: begin
        nv       = r_operand;
        do_write = ((r_expv & mask) == old_m);
      end
      default: nv = r_operand;
    endcase
    nv = nv & mask;

    // per bank address, data and lane enable
    for (int b = 0; b < 8; b++) begin
      k            = 3'(b) - base;
      bank_addr[b] = row0 + ((3'(b) < base) ? RW'(1) : RW'(0));
      wbyte[b]     = nv[8*k +: 8];
      lane_en[b]   = ({1'b0, k} < (4'd1 << lg));
    end
  end

  // byte banks
  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic          we;
    logic [RW-1:0] waddr;
    logic [7:0]    wdata;

    assign we    = cmd.clear ||
                   (cmd.commit && (chk_status == tamu_pkg::ST_OK) && do_write && lane_en[b]);
    assign waddr = cmd.clear ? clear_row : bank_addr[b];
    assign wdata = cmd.clear ? 8'd0 : wbyte[b];

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.read) begin
        rd_word[8*b +: 8] <= mem[bank_addr[b]];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status <= chk_status;
      if (chk_status != tamu_pkg::ST_OK) begin
        old_value <= '0;
      end else if (r_op == tamu_pkg::OP_STORE) begin
        old_value <= r_operand;
      end else begin
        old_value <= tamu_pkg::extend(old_m, lg, sgn);
      end
    end
  end

  assign sts.clear_last = (clear_row == LAST_ROW);
  assign sts.out_free   = !out_valid || out_ready;

endmodule

[src/typed_atomic_memory_unit_top.sv]
// A request passes the check, bank read and commit states before its result is registered
// on rsp; the commit waits while an earlier result is still held unaccepted on rsp.
// Requests are taken one at a time: a new one is accepted only in idle, after the commit.
// A waiting result does not block the next request until the next commit.
// Reset: synchronous; config returns to offset 0, length 0, type i32, then a
// clearing pass over all ceil(STORE_BYTES/8) rows (512 by default) zeroes the store.
// ----------------------------------------------------------------------------
// typed_atomic_memory_unit_top
// atomic load/store/rmw unit over a byte store seen through one typed view
// ----------------------------------------------------------------------------
module typed_atomic_memory_unit_top #(
  parameter int STORE_BYTES = tamu_pkg::DEF_STORE_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tamu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tamu_pkg::CFG_DATA_W-1:0] cfg_data,
  tamu_req_if.sink                        req,
  tamu_rsp_if.source                      rsp
);

  tamu_pkg::tamu_cmd_t cmd;
  tamu_pkg::tamu_sts_t sts;
  logic                in_ready;

  // sequencer
  tamu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  assign req.ready = in_ready;

  // datapath and store
  tamu_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (req.op),
    .elem_index     (req.elem_index),
    .index_invalid  (req.index_invalid),
    .operand        (req.operand),
    .expected_value (req.expected_value),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .old_value      (rsp.old_value),
    .status         (rsp.status),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

[src/tamu_checker.sv]
// ----------------------------------------------------------------------------
// tamu_checker
// port-level checks on the typed atomic memory unit, bound to the top level
// ----------------------------------------------------------------------------
`include "typed_atomic_memory_unit_top_defines.svh"

module tamu_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] rsp_old_value,
  input logic [1:0]  rsp_status
);

  // only defined status codes leave the block
  `TAMU_ASSERT_SAME(a_status_code, rsp_valid, (rsp_status == tamu_pkg::ST_OK) || (rsp_status == tamu_pkg::ST_RANGE) || (rsp_status == tamu_pkg::ST_TYPE), "undefined status code")

  // a rejected request returns zero
  `TAMU_ASSERT_SAME(a_err_zero, rsp_valid && (rsp_status != tamu_pkg::ST_OK), rsp_old_value == 64'd0, "error result carries data")

  // one request at a time: busy right after an accept
  `TAMU_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request taken while busy")

  // stalled response holds
  `TAMU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_old_value) && $stable(rsp_status), "stalled response changed")

endmodule

bind typed_atomic_memory_unit_top tamu_checker u_tamu_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_old_value (rsp.old_value),
  .rsp_status    (rsp.status)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives atomic requests through random views and element types, mirrors
// the byte store in a behavioral model and checks each response in order
// ----------------------------------------------------------------------------
module tb;
  import tamu_pkg::*;

  localparam int MEM_BYTES = DEF_STORE_BYTES;

  // codes past the defined ones
  localparam logic [3:0]           OP_UNKNOWN_MAX = 4'd15;
  localparam logic [3:0]           TY_UNKNOWN_MAX = 4'd15;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] elem_index;
    logic        index_invalid;
    logic [63:0] operand;
    logic [63:0] expected_value;
  } atom_req_t;

  typedef struct packed {
    logic [63:0] old_value;
    logic [1:0]  status;
  } atom_rsp_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tamu_req_if req ();
  tamu_rsp_if rsp ();

  typed_atomic_memory_unit_top #(.STORE_BYTES(MEM_BYTES)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  // mirror of the store and the view
  logic [7:0]  mem_model [MEM_BYTES];
  logic [11:0] view_off;
  logic [12:0] view_len;
  logic [3:0]  view_ty;

  atom_req_t   pending_reqs [$];
  atom_rsp_t   expected_rsps [$];
  atom_req_t   next_req;
  atom_req_t   seen_req;
  atom_rsp_t   want_rsp;
  atom_rsp_t   pred_rsp;
  int unsigned outstanding;
  int unsigned err_count;
  int unsigned req_count;
  logic        req_taken;

  // stretch of requests with no idling on either side
  wire calm = (req_count >= 700) && (req_count < 1000);

  // element size in bytes, zero for unusable types
  function automatic int unsigned elem_bytes(input logic [3:0] ty);
    case (ty)
      TY_I8, TY_U8:   return 1;
      TY_I16, TY_U16: return 2;
      TY_I32, TY_U32: return 4;
      TY_I64, TY_U64: return 8;
      default:        return 0;
    endcase
  endfunction

  function automatic logic [63:0] elem_mask(input int unsigned nb);
    return (nb >= 8) ? '1 : ((64'd1 << (8 * nb)) - 64'd1);
  endfunction

  // one atomic access on the mirror, returns the expected response
  function automatic atom_rsp_t apply_atomic(input atom_req_t r);
    atom_rsp_t   res;
    int unsigned nb;
    int unsigned i;
    logic [63:0] pos;
    logic [63:0] msk;
    logic [63:0] old;
    logic [63:0] nv;
    logic        wr;
    logic        sgn;
    nb = elem_bytes(view_ty);
    sgn = (view_ty == TY_I8) || (view_ty == TY_I16) || (view_ty == TY_I32) ||
          (view_ty == TY_I64);
    res.old_value = '0;
    res.status = ST_OK;
    // unknown op or unusable type
    if (r.op > OP_CAS || nb == 0) begin
      res.status = ST_TYPE;
      return res;
    end
    if (r.index_invalid || r.elem_index >= 32'(view_len)) begin
      res.status = ST_RANGE;
      return res;
    end
    pos = 64'(view_off) + 64'(r.elem_index) * 64'(nb);
    if (pos + 64'(nb) > 64'(MEM_BYTES)) begin
      res.status = ST_RANGE;
      return res;
    end
    // little-endian read
    msk = elem_mask(nb);
    old = '0;
    for (i = 0; i < nb; i++) begin
      old = old | (64'(mem_model[pos + i]) << (8 * i));
    end
    wr = 1'b1;
    case (r.op)
      OP_LOAD: begin
        nv = old;
        wr = 1'b0;
      end
      OP_STORE, OP_XCHG: nv = r.operand;
      OP_ADD:  nv = old + r.operand;
      OP_AND:  nv = old & r.operand;
      OP_OR:   nv = old | r.operand;
      OP_SUB:  nv = old - r.operand;
      OP_XOR:  nv = old ^ r.operand;
      default: begin
        nv = r.operand;
        wr = ((r.expected_value & msk) == old);
      end
    endcase
    if (wr) begin
      for (i = 0; i < nb; i++) begin
        mem_model[pos + i] = nv[8 * i +: 8];
      end
    end
    if (r.op == OP_STORE) begin
      res.old_value = r.operand;
    end else if (sgn && nb < 8 && old[8 * nb - 1]) begin
      res.old_value = old | ~msk;
    end else begin
      res.old_value = old;
    end
    return res;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // monitor: config mirror, request prediction, response check
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
      view_off = '0;
      view_len = '0;
      view_ty = TY_I32;
      foreach (mem_model[i]) mem_model[i] = 8'h00;
    end else begin
      req_taken <= req.valid && req.ready;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_VIEW_OFFSET: view_off = cfg_data[11:0];
          CFG_VIEW_LENGTH: view_len = cfg_data[12:0];
          CFG_ELEM_TYPE:   view_ty = cfg_data[3:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        seen_req = '{req.op, req.elem_index, req.index_invalid, req.operand,
                     req.expected_value};
        pred_rsp = apply_atomic(seen_req);
        expected_rsps = {expected_rsps, pred_rsp};
        req_count++;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected response: old_value %h status %0d", rsp.old_value,
                     rsp.status);
          end
        end else begin
          want_rsp = expected_rsps.pop_front();
          outstanding--;
          if (rsp.old_value !== want_rsp.old_value || rsp.status !== want_rsp.status) begin
            err_count++;
            if (err_count <= 10) begin
              $display("mismatch: expected old_value %h status %0d, got old_value %h status %0d",
                       want_rsp.old_value, want_rsp.status, rsp.old_value, rsp.status);
            end
          end
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
        next_req = pending_reqs.pop_front();
        req.valid <= 1'b1;
        req.op <= next_req.op;
        req.elem_index <= next_req.elem_index;
        req.index_invalid <= next_req.index_invalid;
        req.operand <= next_req.operand;
        req.expected_value <= next_req.expected_value;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // response back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic push_req(input logic [3:0] op, input logic [31:0] idx, input logic inv,
                          input logic [63:0] opnd, input logic [63:0] expv);
    atom_req_t entry;
    entry = '{op, idx, inv, opnd, expv};
    pending_reqs = {pending_reqs, entry};
    outstanding++;
  endtask

  // hold off until every response is back
  task automatic drain_results();
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // random view, then mostly well-formed requests into it
  task automatic random_phase(input int unsigned n_items);
    logic [11:0] off;
    logic [12:0] len;
    logic [3:0]  ty;
    logic [3:0]  op;
    logic [31:0] idx;
    logic        inv;
    logic [63:0] opnd;
    logic [63:0] expv;
    logic [63:0] emsk;
    int unsigned nb;
    int unsigned span;
    int unsigned win;
    int unsigned k;
    drain_results();
    case ($urandom_range(0, 7))
      0:       off = '0;
      1:       off = '1;
      2:       off = 12'($urandom_range(4000, 4095));
      3:       off = 12'($urandom);
      default: off = 12'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 6))
      0:       len = '0;
      1:       len = 13'd4096;
      2:       len = '1;
      3:       len = 13'($urandom);
      4:       len = 13'($urandom_range(1, 512));
      default: len = 13'($urandom_range(1, 32));
    endcase
    k = $urandom_range(0, 19);
    if (k == 0) begin
      ty = TY_U8C;
    end else if (k == 1) begin
      ty = 4'($urandom_range(TY_U64 + 1, TY_UNKNOWN_MAX));
    end else begin
      // usable types only, skipping the clamped one
      ty = 4'($urandom_range(0, 7));
      if (ty >= TY_U8C) ty = ty + 4'd1;
    end
    // unused data bits are set at random to check masking
    write_reg(CFG_VIEW_OFFSET, {1'($urandom), off});
    write_reg(CFG_VIEW_LENGTH, len);
    write_reg(CFG_ELEM_TYPE, {9'($urandom), ty});
    if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 13'($urandom));
    nb = elem_bytes(ty);
    emsk = elem_mask(nb);
    if (nb == 0) begin
      span = len;
    end else begin
      span = (32'(len) < (MEM_BYTES - off) / nb) ? len : (MEM_BYTES - off) / nb;
    end
    win = (span < 8) ? span : 8;
    repeat (n_items) begin
      k = $urandom_range(0, 99);
      op = (k < 92) ? 4'($urandom_range(OP_LOAD, OP_CAS))
                    : 4'($urandom_range(OP_CAS + 1, OP_UNKNOWN_MAX));
      // hot elements at both ends of the usable span, boundaries and noise
      k = $urandom_range(0, 19);
      if (k < 10 && win > 0) begin
        idx = $urandom_range(0, win - 1);
      end else if (k < 13 && win > 0) begin
        idx = span - 1 - $urandom_range(0, win - 1);
      end else if (k < 16 && len > 0) begin
        idx = $urandom_range(0, len - 1);
      end else if (k < 18) begin
        idx = 32'(len) - 1 + $urandom_range(0, 2);
      end else begin
        idx = $urandom;
      end
      inv = ($urandom_range(0, 24) == 0);
      case ($urandom_range(0, 7))
        0, 1, 2: opnd = 64'($urandom_range(0, 3));
        3:       opnd = '1;
        4:       opnd = {1'b1, 63'd0};
        5:       opnd = {1'b0, {63{1'b1}}};
        default: opnd = {$urandom, $urandom};
      endcase
      // small compare values with junk above the element width
      if ($urandom_range(0, 1) == 0) begin
        expv = ({$urandom, $urandom} & ~emsk) | 64'($urandom_range(0, 3));
      end else begin
        expv = {$urandom, $urandom};
      end
      push_req(op, idx, inv, opnd, expv);
    end
  endtask

  // stimulus
  initial begin
    int ph;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.op = OP_LOAD;
    req.elem_index = '0;
    req.index_invalid = 1'b0;
    req.operand = '0;
    req.expected_value = '0;
    rsp.ready = 1'b0;
    outstanding = 0;
    err_count = 0;
    req_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset view has length zero; unknown op beats the range check
    push_req(OP_LOAD, 32'd0, 1'b0, 64'd0, 64'd0);
    push_req(OP_UNKNOWN_MAX, 32'd0, 1'b0, 64'd0, 64'd0);

    // full store as i64: every op, then range edges
    drain_results();
    write_reg(CFG_VIEW_OFFSET, 13'd0);
    write_reg(CFG_VIEW_LENGTH, 13'd4096);
    write_reg(CFG_ELEM_TYPE, 13'(TY_I64));
    push_req(OP_STORE, 32'd0, 1'b0, 64'h8000_0000_0000_0001, 64'd0);
    push_req(OP_LOAD, 32'd0, 1'b0, 64'd0, 64'd0);
    push_req(OP_ADD, 32'd0, 1'b0, '1, 64'd0);
    push_req(OP_SUB, 32'd0, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    push_req(OP_AND, 32'd0, 1'b0, 64'hF0F0_F0F0_F0F0_F0F0, 64'd0);
    push_req(OP_OR, 32'd0, 1'b0, 64'h0000_0000_0000_FFFF, 64'd0);
    push_req(OP_XOR, 32'd0, 1'b0, 64'hAAAA_5555_AAAA_5555, 64'd0);
    push_req(OP_XCHG, 32'd0, 1'b0, 64'h0123_4567_89AB_CDEF, 64'd0);
    push_req(OP_CAS, 32'd0, 1'b0, 64'd5, 64'h0123_4567_89AB_CDEF);
    push_req(OP_CAS, 32'd0, 1'b0, 64'd9, 64'd6);
    push_req(OP_LOAD, 32'd0, 1'b0, 64'd0, 64'd0);
    push_req(OP_LOAD, 32'd0, 1'b1, 64'd0, 64'd0);
    push_req(OP_LOAD, 32'd4096, 1'b0, 64'd0, 64'd0);
    push_req(OP_STORE, 32'd511, 1'b0, '1, 64'd0);
    push_req(OP_LOAD, 32'd511, 1'b0, 64'd0, 64'd0);
    push_req(OP_LOAD, 32'd512, 1'b0, 64'd0, 64'd0);
    push_req(OP_LOAD, 32'hFFFF_FFFF, 1'b0, 64'd0, 64'd0);
    push_req(OP_CAS + 4'd1, 32'd0, 1'b0, 64'd0, 64'd0);

    // clamped type, then an unknown type and a write to the unused index
    drain_results();
    write_reg(CFG_ELEM_TYPE, 13'(TY_U8C));
    push_req(OP_STORE, 32'd0, 1'b0, 64'd1, 64'd0);
    drain_results();
    write_reg(CFG_ELEM_TYPE, {9'h1FF, TY_U64 + 4'd1});
    write_reg(CFG_UNUSED, '1);
    push_req(OP_LOAD, 32'd0, 1'b0, 64'd0, 64'd0);

    // last byte of the store as i8, sign extension of the old value
    drain_results();
    write_reg(CFG_VIEW_OFFSET, '1);
    write_reg(CFG_VIEW_LENGTH, 13'd1);
    write_reg(CFG_ELEM_TYPE, 13'(TY_I8));
    push_req(OP_ADD, 32'd0, 1'b0, 64'h7F, 64'd0);
    push_req(OP_LOAD, 32'd0, 1'b0, 64'd0, 64'd0);
    push_req(OP_STORE, 32'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FF80, 64'd0);
    push_req(OP_LOAD, 32'd0, 1'b0, 64'd0, 64'd0);
    push_req(OP_LOAD, 32'd1, 1'b0, 64'd0, 64'd0);

    for (ph = 0; ph < 18; ph++) begin
      random_phase(100);
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
